// ===== sv/qvr_pkg.sv =====
`default_nettype none

package qvr_pkg;

    localparam int QUAT_BITS = 16;
    localparam int VEC_BITS  = 24;

    // Widths of the intermediate terms.
    localparam int SQ_W   = 2 * QUAT_BITS;
    localparam int N_W    = SQ_W + 1;
    localparam int PROD_W = QUAT_BITS + VEC_BITS;
    localparam int T_W    = PROD_W + 1;
    localparam int S_W    = T_W + QUAT_BITS + 1;
    localparam int NV_W   = N_W + 1 + VEC_BITS;
    localparam int NUM_W  = T_W + QUAT_BITS + 5;
    localparam int DIV_W  = NUM_W + 2;
    localparam int D_W    = N_W + 1;
    localparam int QUO_W  = VEC_BITS - 1;

    typedef logic signed [QUAT_BITS-1:0] t_quat;
    typedef logic signed [VEC_BITS-1:0]  t_vec;

endpackage

`default_nettype wire

// ===== sv/quaternion_vector_rotate_top.sv =====
// Channel | Signals                                   | Direction
// input   | i_valid, o_ready, i_quat_*, i_vec_*       | into the block
// output  | o_valid, i_ready, o_rot_*, o_zero_quat    | out of the block
//
// One transfer is taken in every cycle while the output side keeps up.
// The pipeline holds four arithmetic stages, a sign and overflow stage,
// one quotient bit per stage for 23 stages, and the output register.
// The whole pipeline advances only when the output register is free or taken,
// so a stall holds every stage in place. Reset is synchronous and clears the
// valid bits only.
`default_nettype none

module quaternion_vector_rotate_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  qvr_pkg::t_quat        i_quat_x,
    input  qvr_pkg::t_quat        i_quat_y,
    input  qvr_pkg::t_quat        i_quat_z,
    input  qvr_pkg::t_quat        i_quat_w,
    input  qvr_pkg::t_vec         i_vec_x,
    input  qvr_pkg::t_vec         i_vec_y,
    input  qvr_pkg::t_vec         i_vec_z,
    output logic                  o_valid,
    input  wire                   i_ready,
    output qvr_pkg::t_vec         o_rot_x,
    output qvr_pkg::t_vec         o_rot_y,
    output qvr_pkg::t_vec         o_rot_z,
    output logic                  o_zero_quat
);
    import qvr_pkg::*;

    logic w_en;

    // Stage A: squares and cross-product terms.
    logic                     r_va, r_za;
    logic        [SQ_W-1:0]   r_sq [4];
    logic signed [PROD_W-1:0] r_p  [6];
    t_quat                    r_qa [4];
    t_vec                     r_vA [3];

    // Stage B: norm and t = u x v.
    logic                     r_vb, r_zb;
    logic        [N_W-1:0]    r_nb;
    logic signed [T_W-1:0]    r_tb [3];
    t_quat                    r_qb [4];
    t_vec                     r_vB [3];

    // Stage C: products.
    logic                     r_vc, r_zc;
    logic        [N_W-1:0]    r_nc;
    logic signed [NV_W-1:0]   r_nv [3];
    logic signed [S_W-1:0]    r_tw [3];
    logic signed [S_W-1:0]    r_sp [6];

    // Stage D: numerators.
    logic                     r_vd, r_zd;
    logic        [N_W-1:0]    r_nd;
    logic signed [NUM_W-1:0]  r_num [3];

    // Division pipeline, index 0 is the sign and overflow stage.
    logic                     r_vq  [QUO_W+1];
    logic                     r_zq  [QUO_W+1];
    logic        [D_W-1:0]    r_d   [QUO_W+1];
    logic        [DIV_W-1:0]  r_rem [QUO_W+1][3];
    logic        [QUO_W-1:0]  r_quo [QUO_W+1][3];
    logic                     r_neg [QUO_W+1][3];
    logic                     r_sat [QUO_W+1][3];

    logic                     r_vo;

    function automatic t_vec f_res(input logic zq, input logic ng, input logic st,
                                   input logic [QUO_W-1:0] qv);
        t_vec mx;
        mx = {1'b0, {(VEC_BITS-1){1'b1}}};
        if (zq) begin
            return '0;
        end else if (st) begin
            return ng ? ~mx : mx;
        end else begin
            return ng ? -t_vec'({1'b0, qv}) : t_vec'({1'b0, qv});
        end
    endfunction

    assign w_en    = !r_vo || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_vo <= 1'b0;
            for (int k = 0; k <= QUO_W; k++) begin
                r_vq[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_vq[0] <= r_vd;
            for (int k = 1; k <= QUO_W; k++) begin
                r_vq[k] <= r_vq[k-1];
            end
            r_vo <= r_vq[QUO_W];
        end
    end

    logic [DIV_W-1:0] w_mag [3];
    logic [DIV_W-1:0] w_nn  [3];
    logic [DIV_W-1:0] w_dsh [QUO_W+1];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_mag[c] = r_num[c][NUM_W-1] ? DIV_W'(-r_num[c]) : DIV_W'(r_num[c]);
            w_nn[c]  = (w_mag[c] << 1) + DIV_W'(r_nd);
        end
        for (int k = 0; k <= QUO_W; k++) begin
            w_dsh[k] = DIV_W'(r_d[k]) << (QUO_W - k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_za <= (i_quat_x == '0) && (i_quat_y == '0) &&
                    (i_quat_z == '0) && (i_quat_w == '0);
            r_sq[0] <= SQ_W'(i_quat_x * i_quat_x);
            r_sq[1] <= SQ_W'(i_quat_y * i_quat_y);
            r_sq[2] <= SQ_W'(i_quat_z * i_quat_z);
            r_sq[3] <= SQ_W'(i_quat_w * i_quat_w);
            r_p[0] <= PROD_W'(i_quat_y * i_vec_z);
            r_p[1] <= PROD_W'(i_quat_z * i_vec_y);
            r_p[2] <= PROD_W'(i_quat_z * i_vec_x);
            r_p[3] <= PROD_W'(i_quat_x * i_vec_z);
            r_p[4] <= PROD_W'(i_quat_x * i_vec_y);
            r_p[5] <= PROD_W'(i_quat_y * i_vec_x);
            r_qa[0] <= i_quat_x;
            r_qa[1] <= i_quat_y;
            r_qa[2] <= i_quat_z;
            r_qa[3] <= i_quat_w;
            r_vA[0] <= i_vec_x;
            r_vA[1] <= i_vec_y;
            r_vA[2] <= i_vec_z;

            r_zb <= r_za;
            r_nb <= N_W'(r_sq[0]) + N_W'(r_sq[1]) + N_W'(r_sq[2]) + N_W'(r_sq[3]);
            for (int c = 0; c < 3; c++) begin
                r_tb[c] <= T_W'(r_p[2*c]) - T_W'(r_p[2*c+1]);
                r_vB[c] <= r_vA[c];
            end
            r_qb <= r_qa;

            r_zc <= r_zb;
            r_nc <= r_nb;
            for (int c = 0; c < 3; c++) begin
                r_nv[c] <= NV_W'($signed({1'b0, r_nb})) * NV_W'(r_vB[c]);
                r_tw[c] <= S_W'(r_tb[c]) * S_W'(r_qb[3]);
            end
            r_sp[0] <= S_W'(r_tb[2]) * S_W'(r_qb[1]);
            r_sp[1] <= S_W'(r_tb[1]) * S_W'(r_qb[2]);
            r_sp[2] <= S_W'(r_tb[0]) * S_W'(r_qb[2]);
            r_sp[3] <= S_W'(r_tb[2]) * S_W'(r_qb[0]);
            r_sp[4] <= S_W'(r_tb[1]) * S_W'(r_qb[0]);
            r_sp[5] <= S_W'(r_tb[0]) * S_W'(r_qb[1]);

            r_zd <= r_zc;
            r_nd <= r_nc;
            for (int c = 0; c < 3; c++) begin
                r_num[c] <= NUM_W'(r_nv[c]) +
                            ((NUM_W'(r_tw[c]) + NUM_W'(r_sp[2*c]) -
                              NUM_W'(r_sp[2*c+1])) <<< 1);
            end

            r_zq[0] <= r_zd;
            r_d[0]  <= {r_nd, 1'b0};
            for (int c = 0; c < 3; c++) begin
                r_neg[0][c] <= r_num[c][NUM_W-1];
                r_rem[0][c] <= w_nn[c];
                r_quo[0][c] <= '0;
                r_sat[0][c] <= w_nn[c] >= (DIV_W'({r_nd, 1'b0}) << QUO_W);
            end

            for (int k = 1; k <= QUO_W; k++) begin
                r_zq[k] <= r_zq[k-1];
                r_d[k]  <= r_d[k-1];
                for (int c = 0; c < 3; c++) begin
                    r_neg[k][c] <= r_neg[k-1][c];
                    r_sat[k][c] <= r_sat[k-1][c];
                    if (r_rem[k-1][c] >= w_dsh[k-1] >> 1) begin
                        r_rem[k][c] <= r_rem[k-1][c] - (w_dsh[k-1] >> 1);
                        r_quo[k][c] <= r_quo[k-1][c] | (QUO_W'(1) << (QUO_W - k));
                    end else begin
                        r_rem[k][c] <= r_rem[k-1][c];
                        r_quo[k][c] <= r_quo[k-1][c];
                    end
                end
            end

            o_zero_quat <= r_zq[QUO_W];
            o_rot_x <= f_res(r_zq[QUO_W], r_neg[QUO_W][0], r_sat[QUO_W][0],
                             r_quo[QUO_W][0]);
            o_rot_y <= f_res(r_zq[QUO_W], r_neg[QUO_W][1], r_sat[QUO_W][1],
                             r_quo[QUO_W][1]);
            o_rot_z <= f_res(r_zq[QUO_W], r_neg[QUO_W][2], r_sat[QUO_W][2],
                             r_quo[QUO_W][2]);
        end
    end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import qvr_pkg::*;

    typedef struct packed {
        t_quat qx, qy, qz, qw;
        t_vec  vx, vy, vz;
    } t_pose;

    typedef struct packed {
        t_vec rx, ry, rz;
        logic zq;
    } t_rot;

    localparam int WATCHDOG = 2000;
    localparam int N_RANDOM = 1500;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_ready = 1'b0;
    logic o_ready, o_valid, o_zero_quat;
    t_quat i_quat_x = '0, i_quat_y = '0, i_quat_z = '0, i_quat_w = '0;
    t_vec i_vec_x = '0, i_vec_y = '0, i_vec_z = '0;
    t_vec o_rot_x, o_rot_y, o_rot_z;

    t_pose pending_poses[$];
    t_rot  expected_rots[$];
    int    errors = 0;
    int    rots_checked = 0;
    int    zero_quats_seen = 0;
    int    idle_cycles = 0;
    int    send_gap = 0;
    int    recv_gap = 0;
    bit    calm = 1'b0;
    bit    in_taken = 1'b0;

    quaternion_vector_rotate_top dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Rounds num/den to nearest with ties away from zero, then clamps.
    function automatic t_vec round_clamp(logic signed [127:0] num,
                                         logic signed [127:0] den);
        logic signed [127:0] mag, quo;
        logic signed [127:0] lim;
        lim = 128'sd1 <<< (VEC_BITS - 1);
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + den) / (2 * den);
        if (num < 0)
            return (quo >= lim) ? t_vec'(-lim) : t_vec'(-quo);
        return (quo >= lim) ? t_vec'(lim - 1) : t_vec'(quo);
    endfunction

    function automatic t_rot rotate_vector(t_pose p);
        logic signed [127:0] x, y, z, w, vx, vy, vz, n, tx, ty, tz, sx, sy, sz;
        t_rot r;
        x = p.qx; y = p.qy; z = p.qz; w = p.qw;
        vx = p.vx; vy = p.vy; vz = p.vz;
        r = '0;
        if (x == 0 && y == 0 && z == 0 && w == 0) begin
            r.zq = 1'b1;
            return r;
        end
        n = x * x + y * y + z * z + w * w;
        tx = y * vz - z * vy;
        ty = z * vx - x * vz;
        tz = x * vy - y * vx;
        sx = tz * y - ty * z;
        sy = tx * z - tz * x;
        sz = ty * x - tx * y;
        r.rx = round_clamp(n * vx + 2 * (tx * w + sx), n);
        r.ry = round_clamp(n * vy + 2 * (ty * w + sy), n);
        r.rz = round_clamp(n * vz + 2 * (tz * w + sz), n);
        return r;
    endfunction

    function automatic t_quat rand_quat(int mode);
        case (mode)
            0: return t_quat'($urandom);
            1: return t_quat'($urandom_range(0, 32768) - 16384);
            default: return t_quat'($urandom_range(0, 8) - 4);
        endcase
    endfunction

    function automatic t_vec rand_vec(int mode);
        case (mode)
            0: return t_vec'($urandom);
            1: return t_vec'($urandom_range(0, 65536) - 32768);
            default: return t_vec'($urandom_range(0, 16) - 8);
        endcase
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        int qm, vm;
        qm = $urandom_range(0, 2);
        vm = $urandom_range(0, 2);
        p.qx = rand_quat(qm); p.qy = rand_quat(qm);
        p.qz = rand_quat(qm); p.qw = rand_quat(qm);
        p.vx = rand_vec(vm); p.vy = rand_vec(vm); p.vz = rand_vec(vm);
        if ($urandom_range(0, 19) == 0) begin
            p.qx = '0; p.qy = '0; p.qz = '0; p.qw = '0;
        end
        return p;
    endfunction

    // Driver: the payload only changes once the previous transfer is done.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_poses.size() > 0 &&
                             !(i_valid && in_taken && !calm && $urandom_range(0, 9) == 0)) begin
                    t_pose p;
                    p = pending_poses.pop_front();
                    expected_rots.push_back(rotate_vector(p));
                    {i_quat_x, i_quat_y, i_quat_z, i_quat_w, i_vec_x, i_vec_y, i_vec_z} <= p;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(0, 10);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                recv_gap <= $urandom_range(0, 10);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor and watchdog.
    always @(posedge i_clk) begin
        in_taken <= i_valid && o_ready;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: watchdog expired, %0d results outstanding",
                         $realtime, expected_rots.size());
                $display("Simulation FAILED");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (expected_rots.size() == 0) begin
                    errors <= errors + 1;
                    $display("%0t: unexpected transfer rot=(%0d,%0d,%0d) zero=%0b",
                             $realtime, o_rot_x, o_rot_y, o_rot_z, o_zero_quat);
                end else begin
                    t_rot e;
                    e = expected_rots.pop_front();
                    rots_checked <= rots_checked + 1;
                    if (e.zq) zero_quats_seen <= zero_quats_seen + 1;
                    if (o_rot_x !== e.rx || o_rot_y !== e.ry ||
                        o_rot_z !== e.rz || o_zero_quat !== e.zq) begin
                        errors <= errors + 1;
                        $display("%0t: mismatch expected (%0d,%0d,%0d) zero=%0b",
                                 $realtime, e.rx, e.ry, e.rz, e.zq);
                        $display("%0t:          actual   (%0d,%0d,%0d) zero=%0b",
                                 $realtime, o_rot_x, o_rot_y, o_rot_z, o_zero_quat);
                    end
                end
            end
        end
    end

    task automatic add_pose(int qx, int qy, int qz, int qw, int vx, int vy, int vz);
        t_pose p;
        p.qx = t_quat'(qx); p.qy = t_quat'(qy); p.qz = t_quat'(qz); p.qw = t_quat'(qw);
        p.vx = t_vec'(vx); p.vy = t_vec'(vy); p.vz = t_vec'(vz);
        pending_poses.push_back(p);
    endtask

    task automatic drain();
        while (pending_poses.size() > 0 || i_valid || expected_rots.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_pose(0, 0, 0, 0, 256, -256, 8388607);
        add_pose(0, 0, 0, 16384, 256, 512, 768);
        add_pose(16384, 0, 0, 0, 256, 512, 768);
        add_pose(0, 16384, 0, 0, 256, 512, 768);
        add_pose(0, 0, 16384, 0, 256, 512, 768);
        add_pose(11585, 0, 0, 11585, 8388607, -8388608, 1000);
        add_pose(-32768, -32768, -32768, -32768, 8388607, 8388607, 8388607);
        add_pose(32767, 32767, 32767, 32767, -8388608, -8388608, -8388608);
        add_pose(1, 0, 0, 0, -1, 1, 0);
        add_pose(0, 0, 0, 1, 8388607, -8388608, 0);
        add_pose(1, 1, 0, 0, 8388607, 8388607, 8388607);
        add_pose(32767, 0, 0, 1, 1, 1, 1);
        add_pose(1, 1, 1, 1, 1, 0, 0);
        add_pose(-1, 2, -3, 4, 3, -5, 7);
        add_pose(-32768, 0, 0, 0, -8388608, 0, 0);
        add_pose(0, -32768, 32767, 0, 0, -8388608, 8388607);
        // The sender holds off here until the pipeline is empty.
        drain();

        repeat (N_RANDOM - 200) pending_poses.push_back(rand_pose());
        drain();
        calm = 1'b1;
        repeat (200) pending_poses.push_back(rand_pose());
        drain();
        repeat (40) @(posedge i_clk);

        $display("Checked %0d rotated vectors, %0d of them with a zero quaternion,",
                 rots_checked, zero_quats_seen);
        $display("under random input gaps and output stalls, then at full rate.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ===== sim.f =====
sv/qvr_pkg.sv
sv/quaternion_vector_rotate_top.sv
dv/testbench.sv
